/* src/mpfg_pkg.sv */
// Package for the motion path frame generator: shared types and constants.
// Used by the controller, the datapath and the top level.
`default_nettype none
package mpfg_pkg;

  localparam int unsigned TABLE_LEN = 24;
  localparam int unsigned POS_W = 34;
  localparam int unsigned GAIN_Q24 = 10188014;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_DIV_START,
    CMD_DIV_STEP,
    CMD_DIV_STORE,
    CMD_ROT_LOAD,
    CMD_ROT_STEP,
    CMD_ROT_STORE,
    CMD_TRANSLATE
  } cmd_e;

  typedef struct packed {
    cmd_e        op;
    logic [1:0]  div_sel;
  } ctrl_t;

  typedef struct packed {
    logic div_zero;
    logic rotating;
    logic turn_zero;
    logic frames_zero;
  } stat_t;

  function automatic logic signed [39:0] atan_entry(input logic [4:0] i);
    logic signed [39:0] r;
    case (i)
      5'd0: r = 40'sd294912000;
      5'd1: r = 40'sd174096719;
      5'd2: r = 40'sd91987925;
      5'd3: r = 40'sd46694507;
      5'd4: r = 40'sd23437865;
      5'd5: r = 40'sd11730358;
      5'd6: r = 40'sd5866610;
      5'd7: r = 40'sd2933484;
      5'd8: r = 40'sd1466764;
      5'd9: r = 40'sd733385;
      5'd10: r = 40'sd366693;
      5'd11: r = 40'sd183346;
      5'd12: r = 40'sd91673;
      5'd13: r = 40'sd45837;
      5'd14: r = 40'sd22918;
      5'd15: r = 40'sd11459;
      5'd16: r = 40'sd5730;
      5'd17: r = 40'sd2865;
      5'd18: r = 40'sd1432;
      5'd19: r = 40'sd716;
      5'd20: r = 40'sd358;
      5'd21: r = 40'sd179;
      5'd22: r = 40'sd90;
      5'd23: r = 40'sd45;
      default: r = 40'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/mpfg_datapath.sv */
// Datapath of the motion path frame generator: segment state, a restoring
// divider, gain scaling and a shared CORDIC stage. Depends on mpfg_pkg.
`default_nettype none
module mpfg_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  mpfg_pkg::ctrl_t          ctrl_i,
  input  wire logic [4:0]          iter_i,
  input  wire logic                load_i,
  input  wire logic signed [12:0]  move_x_i,
  input  wire logic signed [12:0]  move_y_i,
  input  wire logic [7:0]          seconds_i,
  input  wire logic signed [19:0]  angle_centideg_i,
  input  wire logic [6:0]          frame_rate_i,
  input  wire logic                tick_i,
  input  wire logic                out_load_i,
  output mpfg_pkg::stat_t          stat_o,
  output logic signed [15:0]       disp_x_o,
  output logic signed [15:0]       disp_y_o,
  output logic                     segment_done_o,
  output logic                     no_frames_left_o
);
  import mpfg_pkg::*;

  localparam int unsigned NW = 13 + FRAC_BITS;
  localparam int unsigned EW = POS_W + 2;
  localparam int unsigned TURN_RECIP = 954438;

  logic signed [POS_W-1:0] pos_x_q, pos_y_q, step_x_q, step_y_q;
  logic signed [12:0] pivot_x_q, pivot_y_q;
  logic signed [19:0] turn_q;
  logic [14:0] frames_rem_q;
  logic [14:0] frames_q;
  logic rotating_q;

  logic signed [12:0] mx_q, my_q;
  logic signed [19:0] ang_q;
  logic done_q, empty_q;

  logic [NW-1:0] rem_q, quo_q;
  logic [NW-1:0] num_q;
  logic neg_q;
  logic [NW:0] trial;

  logic signed [EW-1:0] cx_q, cy_q;
  logic signed [39:0] cz_q;
  logic signed [POS_W-1:0] px, py;
  logic signed [EW-1:0] xs, ys;
  logic signed [EW-1:0] sum_x, sum_y;
  logic signed [POS_W-1:0] sat_x, sat_y;
  logic signed [POS_W:0] tr_x, tr_y;
  logic signed [POS_W-1:0] tsat_x, tsat_y;
  logic signed [POS_W:0] dx, dy;
  logic signed [POS_W+25:0] gx, gy;
  logic signed [20:0] ang_b, amod_w;
  logic [39:0] recip_p;
  logic [4:0] wrap_q;
  logic signed [19:0] amod;
  logic signed [19:0] ared;
  logic [15:0] frames_full;
  logic signed [NW-1:0] quo_s;

  function automatic logic signed [POS_W-1:0] sat_e(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] mx, mn;
    mx = EW'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
    mn = -mx - EW'(1);
    if (v > mx) return mx[POS_W-1:0];
    if (v < mn) return mn[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

  function automatic logic signed [15:0] out16(input logic signed [POS_W-1:0] p);
    logic signed [POS_W-1:0] i;
    i = (p >= 0) ? (p >>> FRAC_BITS) : -((-p) >>> FRAC_BITS);
    if (i > 32767) return 16'sh7fff;
    if (i < -32768) return 16'sh8000;
    return i[15:0];
  endfunction

  assign frames_full = 16'(seconds_i) * 16'(frame_rate_i);
  assign trial = {rem_q, num_q[NW-1]} - {1'b0, NW'(frames_q)};
  assign quo_s = neg_q ? -$signed(quo_q) : $signed(quo_q);

  assign px = POS_W'(pivot_x_q) <<< FRAC_BITS;
  assign py = POS_W'(pivot_y_q) <<< FRAC_BITS;
  assign dx = (POS_W+1)'(pos_x_q) - (POS_W+1)'(px);
  assign dy = (POS_W+1)'(pos_y_q) - (POS_W+1)'(py);
  assign gx = (POS_W+26)'(dx) * (POS_W+26)'($signed({1'b0, 24'(GAIN_Q24)}));
  assign gy = (POS_W+26)'(dy) * (POS_W+26)'($signed({1'b0, 24'(GAIN_Q24)}));

  // The turn is folded into one full circle by a reciprocal multiplication.
  assign ang_b = 21'(turn_q) + 21'sd378000;
  assign recip_p = 40'(ang_b[19:0]) * 40'(TURN_RECIP);
  assign amod_w = ang_b - 21'sd18000 - $signed(21'(wrap_q)) * 21'sd36000;
  assign amod = amod_w[19:0];
  always_comb begin
    ared = amod;
    if (ared > 20'sd18000) ared = ared - 20'sd36000;
    if (ared < -20'sd18000) ared = ared + 20'sd36000;
  end

  assign xs = cx_q >>> iter_i;
  assign ys = cy_q >>> iter_i;
  assign sum_x = EW'(px) + cx_q;
  assign sum_y = EW'(py) + cy_q;
  assign sat_x = sat_e(sum_x);
  assign sat_y = sat_e(sum_y);
  assign tr_x = (POS_W+1)'(pos_x_q) + (POS_W+1)'(step_x_q);
  assign tr_y = (POS_W+1)'(pos_y_q) + (POS_W+1)'(step_y_q);
  assign tsat_x = sat_e(EW'(tr_x));
  assign tsat_y = sat_e(EW'(tr_y));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      step_x_q <= '0;
      step_y_q <= '0;
      pivot_x_q <= '0;
      pivot_y_q <= '0;
      turn_q <= '0;
      frames_rem_q <= '0;
      frames_q <= '0;
      rotating_q <= 1'b0;
    end else begin
      if (load_i) begin
        frames_rem_q <= frames_full[14:0];
        frames_q <= frames_full[14:0];
        step_x_q <= '0;
        step_y_q <= '0;
        turn_q <= '0;
        rotating_q <= (angle_centideg_i != 20'sd0);
        if (angle_centideg_i != 20'sd0) begin
          pivot_x_q <= move_x_i;
          pivot_y_q <= move_y_i;
        end
      end
      if (ctrl_i.op == CMD_DIV_STORE) begin
        case (ctrl_i.div_sel)
          2'd0: step_x_q <= POS_W'(quo_s);
          2'd1: step_y_q <= POS_W'(quo_s);
          default: turn_q <= 20'(quo_s);
        endcase
      end
      if (ctrl_i.op == CMD_TRANSLATE) begin
        pos_x_q <= tsat_x;
        pos_y_q <= tsat_y;
      end
      if (ctrl_i.op == CMD_ROT_STORE) begin
        pos_x_q <= sat_x;
        pos_y_q <= sat_y;
      end
      if (tick_i && frames_rem_q != '0) frames_rem_q <= frames_rem_q - 15'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    wrap_q <= recip_p[39:35];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mx_q <= move_x_i;
      my_q <= move_y_i;
      ang_q <= angle_centideg_i;
    end
    case (ctrl_i.op)
      CMD_DIV_START: begin
        rem_q <= '0;
        quo_q <= '0;
        case (ctrl_i.div_sel)
          2'd0: begin
            neg_q <= mx_q[12];
            num_q <= mx_q[12] ? NW'(-(NW'(mx_q) <<< FRAC_BITS))
                              : NW'(NW'(mx_q) <<< FRAC_BITS);
          end
          2'd1: begin
            neg_q <= my_q[12];
            num_q <= my_q[12] ? NW'(-(NW'(my_q) <<< FRAC_BITS))
                              : NW'(NW'(my_q) <<< FRAC_BITS);
          end
          default: begin
            neg_q <= ang_q[19];
            num_q <= ang_q[19] ? NW'(-(NW'(ang_q))) : NW'(NW'(ang_q));
          end
        endcase
      end
      CMD_DIV_STEP: begin
        num_q <= num_q << 1;
        if (!trial[NW]) begin
          rem_q <= trial[NW-1:0];
          quo_q <= {quo_q[NW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[NW-2:0], num_q[NW-1]};
          quo_q <= {quo_q[NW-2:0], 1'b0};
        end
      end
      CMD_ROT_LOAD: begin
        if (ared > 20'sd9000) begin
          cx_q <= -EW'(gx >>> 24);
          cy_q <= -EW'(gy >>> 24);
          cz_q <= 40'(ared - 20'sd18000) * 40'sd65536;
        end else if (ared < -20'sd9000) begin
          cx_q <= -EW'(gx >>> 24);
          cy_q <= -EW'(gy >>> 24);
          cz_q <= 40'(ared + 20'sd18000) * 40'sd65536;
        end else begin
          cx_q <= EW'(gx >>> 24);
          cy_q <= EW'(gy >>> 24);
          cz_q <= 40'(ared) * 40'sd65536;
        end
      end
      CMD_ROT_STEP: begin
        if (cz_q >= 0) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - atan_entry(iter_i);
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + atan_entry(iter_i);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tick_i) begin
      done_q <= (frames_rem_q == 15'd1);
      empty_q <= (frames_rem_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_x_o <= '0;
      disp_y_o <= '0;
      segment_done_o <= 1'b0;
      no_frames_left_o <= 1'b0;
    end else if (out_load_i) begin
      disp_x_o <= out16(pos_x_q);
      disp_y_o <= out16(pos_y_q);
      segment_done_o <= done_q;
      no_frames_left_o <= empty_q;
    end
  end

  assign stat_o.div_zero = 1'b0;
  assign stat_o.rotating = rotating_q;
  assign stat_o.turn_zero = (turn_q == '0);
  assign stat_o.frames_zero = (frames_rem_q == '0);
endmodule
`default_nettype wire

/* src/mpfg_ctrl.sv */
// Controller of the motion path frame generator: sequences segment divisions
// and per-frame updates. Depends on mpfg_pkg.
`default_nettype none
module mpfg_ctrl #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        action_i,
  input  wire logic        angle_nz_i,
  input  wire logic        frames_nz_i,
  input  mpfg_pkg::stat_t  stat_i,
  output mpfg_pkg::ctrl_t  ctrl_o,
  output logic [4:0]       iter_o,
  output logic             load_o,
  output logic             tick_o,
  output logic             out_load_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i
);
  import mpfg_pkg::*;

  localparam int unsigned NW = 13 + FRAC_BITS;
  localparam int unsigned STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DSTART, ST_DSTEP, ST_DSTORE, ST_TICK, ST_RLOAD, ST_RSTEP,
    ST_RSTORE, ST_TRANS, ST_OUT
  } state_e;

  state_e state_q;
  logic [5:0] cnt_q;
  logic [1:0] sel_q;
  logic last_sel_q;
  logic accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept = in_valid_i && !in_stall_o;
  assign load_o = accept && !action_i;
  assign iter_o = cnt_q[4:0];
  assign tick_o = (state_q == ST_TICK);
  assign out_load_o = (state_q == ST_OUT) && (!out_valid_o || !out_stall_i);

  always_comb begin
    ctrl_o.div_sel = sel_q;
    case (state_q)
      ST_DSTART: ctrl_o.op = CMD_DIV_START;
      ST_DSTEP: ctrl_o.op = CMD_DIV_STEP;
      ST_DSTORE: ctrl_o.op = CMD_DIV_STORE;
      ST_RLOAD: ctrl_o.op = CMD_ROT_LOAD;
      ST_RSTEP: ctrl_o.op = CMD_ROT_STEP;
      ST_RSTORE: ctrl_o.op = CMD_ROT_STORE;
      ST_TRANS: ctrl_o.op = CMD_TRANSLATE;
      default: ctrl_o.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      sel_q <= '0;
      last_sel_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_load_o) out_valid_o <= 1'b1;
      else if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (action_i) begin
              state_q <= ST_TICK;
            end else if (frames_nz_i) begin
              sel_q <= angle_nz_i ? 2'd2 : 2'd0;
              last_sel_q <= angle_nz_i;
              state_q <= ST_DSTART;
            end
          end
        end
        ST_DSTART: begin
          cnt_q <= '0;
          state_q <= ST_DSTEP;
        end
        ST_DSTEP: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(NW - 1)) state_q <= ST_DSTORE;
        end
        ST_DSTORE: begin
          if (last_sel_q || sel_q == 2'd1) begin
            state_q <= ST_IDLE;
          end else begin
            sel_q <= 2'd1;
            state_q <= ST_DSTART;
          end
        end
        ST_TICK: begin
          if (stat_i.frames_zero) state_q <= ST_OUT;
          else if (!stat_i.rotating) state_q <= ST_TRANS;
          else if (stat_i.turn_zero) state_q <= ST_OUT;
          else state_q <= ST_RLOAD;
        end
        ST_RLOAD: begin
          cnt_q <= '0;
          state_q <= ST_RSTEP;
        end
        ST_RSTEP: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(STEPS - 1)) state_q <= ST_RSTORE;
        end
        ST_RSTORE: state_q <= ST_OUT;
        ST_TRANS: state_q <= ST_OUT;
        ST_OUT: begin
          if (out_load_o) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/motion_path_frame_generator.sv */
// Top level of the motion path frame generator; joins mpfg_ctrl and
// mpfg_datapath and holds the frame_rate register. Depends on mpfg_pkg.
// A segment start with zero frames only loads the segment; otherwise it also runs the two
// step divisions, or one turn division for a rotation. A tick goes straight to output when
// exhausted or the turn is zero, translates when not rotating, and else runs the CORDIC
// rotation steps; outputs are registered. Reset clears state and sets frame_rate to 30.
`default_nettype none
module motion_path_frame_generator #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [6:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               action_i,
  input  wire logic signed [12:0] move_x_i,
  input  wire logic signed [12:0] move_y_i,
  input  wire logic [7:0]         seconds_i,
  input  wire logic signed [19:0] angle_centideg_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      disp_x_o,
  output logic signed [15:0]      disp_y_o,
  output logic                    segment_done_o,
  output logic                    no_frames_left_o
);
  import mpfg_pkg::*;

  logic [6:0] frame_rate_q;
  ctrl_t ctrl;
  stat_t stat;
  logic [4:0] iter;
  logic load, tick;
  logic out_load;
  logic frames_nz;

  assign cfg_ready_o = 1'b1;
  assign frames_nz = (seconds_i != '0) && (frame_rate_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) frame_rate_q <= 7'd30;
    else if (cfg_valid_i) frame_rate_q <= cfg_data_i;
  end

  mpfg_ctrl #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i,
    .angle_nz_i(angle_centideg_i != 20'sd0), .frames_nz_i(frames_nz),
    .stat_i(stat), .ctrl_o(ctrl), .iter_o(iter), .load_o(load), .tick_o(tick),
    .out_load_o(out_load), .out_valid_o, .out_stall_i
  );

  mpfg_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .iter_i(iter), .load_i(load),
    .move_x_i, .move_y_i, .seconds_i, .angle_centideg_i,
    .frame_rate_i(frame_rate_q), .tick_i(tick), .out_load_i(out_load), .stat_o(stat),
    .disp_x_o, .disp_y_o, .segment_done_o, .no_frames_left_o
  );
endmodule
`default_nettype wire

/* src/mpfg_checker.sv */
// Port-level checks for the motion path frame generator, bound to the top.
// Depends only on the top level's ports.
`default_nettype none
module mpfg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [15:0] disp_x_o,
  input wire logic [15:0] disp_y_o,
  input wire logic        segment_done_o,
  input wire logic        no_frames_left_o
);
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(segment_done_o && no_frames_left_o)) else $error("flags");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("out hold");
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable({disp_x_o, disp_y_o, segment_done_o, no_frames_left_o})) else $error("stable");
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_stall_o, out_valid_o})) else $error("known");
endmodule

bind motion_path_frame_generator mpfg_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .disp_x_o, .disp_y_o, .segment_done_o, .no_frames_left_o
);
`default_nettype wire
